>>> rtl/rpb_pkg.sv
// Shared types and constants for the relay pulse/blink driver.
// No dependencies; imported by every other rtl file.
package rpb_pkg;

    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_ON     = 3'd1,
        CMD_OFF    = 3'd2,
        CMD_TOGGLE = 3'd3,
        CMD_PULSE  = 3'd4,
        CMD_BLINK  = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        REG_RELAY_ENABLED = 2'd0,
        REG_ACTIVE_LOW    = 2'd1,
        REG_INITIAL_ON    = 2'd2,
        REG_MIN_INTERVAL  = 2'd3
    } t_reg_idx;

    localparam int unsigned ADDR_W = 4;

    // Configuration as seen by the core, plus a one-cycle reload of the relay state
    typedef struct packed {
        logic        relay_enabled;
        logic        active_low;
        logic        initial_on;
        logic [31:0] min_interval;
        logic        load_init;
        logic        load_val;
    } t_cfg;

    typedef struct packed {
        logic blinking;
        logic pulsing;
        logic relay_on;
        logic pin_level;
    } t_res;

endpackage

>>> rtl/rpb_apb_regs.sv
// APB configuration registers for the relay driver.
// Depends on rpb_pkg.
module rpb_apb_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rpb_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output rpb_pkg::t_cfg              o_cfg
);
    import rpb_pkg::*;

    logic        r_relay_enabled;
    logic        r_active_low;
    logic        r_initial_on;
    logic [31:0] r_min_interval;
    logic        w_wr;
    t_reg_idx    w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relay_enabled <= 1'b1;
            r_active_low    <= 1'b0;
            r_initial_on    <= 1'b0;
            r_min_interval  <= 32'd0;
        end else if (w_wr) begin
            case (w_idx)
                REG_RELAY_ENABLED: r_relay_enabled <= pwdata[0];
                REG_ACTIVE_LOW:    r_active_low    <= pwdata[0];
                REG_INITIAL_ON:    r_initial_on    <= pwdata[0];
                REG_MIN_INTERVAL:  r_min_interval  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_RELAY_ENABLED: prdata = {31'd0, r_relay_enabled};
            REG_ACTIVE_LOW:    prdata = {31'd0, r_active_low};
            REG_INITIAL_ON:    prdata = {31'd0, r_initial_on};
            REG_MIN_INTERVAL:  prdata = r_min_interval;
            default:           prdata = 32'd0;
        endcase
    end

    // writing initial_on re-initialises the relay state, only with a pin present
    always_comb begin
        o_cfg.relay_enabled = r_relay_enabled;
        o_cfg.active_low    = r_active_low;
        o_cfg.initial_on    = r_initial_on;
        o_cfg.min_interval  = r_min_interval;
        o_cfg.load_init     = w_wr && (w_idx == REG_INITIAL_ON) && r_relay_enabled;
        o_cfg.load_val      = pwdata[0];
    end

endmodule

>>> rtl/rpb_core.sv
// Relay state, millisecond clock and pulse/blink timers; one command per step.
// Depends on rpb_pkg.
module rpb_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rpb_pkg::t_cfg i_cfg,
    input  logic          i_step,
    input  logic [2:0]    i_cmd,
    input  logic [31:0]   i_dur,
    input  logic [31:0]   i_off,
    input  logic [7:0]    i_rep,
    output rpb_pkg::t_res o_res
);
    import rpb_pkg::*;

    logic [31:0] r_time, n_time;
    logic [31:0] r_time_inc, n_time_inc;   // always r_time + 1
    logic [31:0] r_last, n_last;
    logic        r_relay, n_relay;
    logic        r_pulse, n_pulse;
    logic [31:0] r_pstart, n_pstart;
    logic [31:0] r_plen, n_plen;
    logic        r_blink, n_blink;
    logic [31:0] r_mark, n_mark;
    logic [31:0] r_on, n_on;
    logic [31:0] r_offt, n_offt;
    logic [7:0]  r_target, n_target;
    logic [7:0]  r_done, n_done;

    always_comb begin
        logic [31:0] t;
        logic        guard, guard2, sw1, rs, no_guard;
        logic [7:0]  cnt1;

        n_time     = r_time;
        n_time_inc = r_time_inc;
        n_last     = r_last;
        n_relay    = r_relay;
        n_pulse    = r_pulse;
        n_pstart   = r_pstart;
        n_plen     = r_plen;
        n_blink    = r_blink;
        n_mark     = r_mark;
        n_on       = r_on;
        n_offt     = r_offt;
        n_target   = r_target;
        n_done     = r_done;

        t        = (i_cmd == CMD_TICK) ? r_time_inc : r_time;
        no_guard = (i_cfg.min_interval == 32'd0);
        guard    = no_guard || ((t - r_last) >= i_cfg.min_interval);
        guard2   = guard;
        sw1      = 1'b0;
        rs       = r_relay;
        cnt1     = r_done + 8'd1;

        if (i_step) begin
            if (i_cmd == CMD_TICK) begin
                n_time     = r_time_inc;
                n_time_inc = r_time_inc + 32'd1;
                if (i_cfg.relay_enabled) begin
                    if (r_pulse && ((t - r_pstart) >= r_plen)) begin
                        n_pulse = 1'b0;
                        if (guard) begin
                            rs     = 1'b0;
                            n_last = t;
                            sw1    = 1'b1;
                        end
                    end
                    // a switch just taken leaves zero elapsed time for the next one
                    guard2 = sw1 ? no_guard : guard;
                    if (r_blink) begin
                        if (rs) begin
                            if ((t - r_mark) >= r_on) begin
                                if (guard2) begin
                                    rs     = 1'b0;
                                    n_last = t;
                                end
                                n_mark = t;
                            end
                        end else if ((t - r_mark) >= r_offt) begin
                            n_done = cnt1;
                            if ((r_target != 8'd0) && (cnt1 >= r_target)) begin
                                n_blink = 1'b0;
                            end else begin
                                if (guard2) begin
                                    rs     = 1'b1;
                                    n_last = t;
                                end
                                n_mark = t;
                            end
                        end
                    end
                    n_relay = rs;
                end
            end else if (i_cfg.relay_enabled) begin
                case (i_cmd)
                    CMD_ON, CMD_OFF, CMD_TOGGLE: begin
                        n_pulse = 1'b0;
                        n_blink = 1'b0;
                        if (guard) begin
                            n_last = t;
                            if (i_cmd == CMD_ON)       n_relay = 1'b1;
                            else if (i_cmd == CMD_OFF) n_relay = 1'b0;
                            else                       n_relay = ~r_relay;
                        end
                    end
                    CMD_PULSE: begin
                        if (i_dur != 32'd0) begin
                            n_blink  = 1'b0;
                            n_pulse  = 1'b1;
                            n_pstart = t;
                            n_plen   = i_dur;
                            if (guard) begin
                                n_relay = 1'b1;
                                n_last  = t;
                            end
                        end
                    end
                    CMD_BLINK: begin
                        if ((i_dur != 32'd0) && (i_off != 32'd0)) begin
                            n_pulse  = 1'b0;
                            n_on     = i_dur;
                            n_offt   = i_off;
                            n_target = i_rep;
                            n_done   = 8'd0;
                            n_blink  = 1'b1;
                            n_mark   = t;
                            if (guard) begin
                                n_relay = 1'b1;
                                n_last  = t;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end

        if (i_cfg.load_init) begin
            n_relay = i_cfg.load_val;
        end

        o_res.pin_level = i_cfg.relay_enabled && (n_relay ^ i_cfg.active_low);
        o_res.relay_on  = n_relay;
        o_res.pulsing   = n_pulse;
        o_res.blinking  = n_blink;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time     <= 32'd0;
            r_time_inc <= 32'd1;
            r_last     <= 32'd0;
            r_relay    <= 1'b0;
            r_pulse    <= 1'b0;
            r_pstart   <= 32'd0;
            r_plen     <= 32'd0;
            r_blink    <= 1'b0;
            r_mark     <= 32'd0;
            r_on       <= 32'd0;
            r_offt     <= 32'd0;
            r_target   <= 8'd0;
            r_done     <= 8'd0;
        end else begin
            r_time     <= n_time;
            r_time_inc <= n_time_inc;
            r_last     <= n_last;
            r_relay    <= n_relay;
            r_pulse    <= n_pulse;
            r_pstart   <= n_pstart;
            r_plen     <= n_plen;
            r_blink    <= n_blink;
            r_mark     <= n_mark;
            r_on       <= n_on;
            r_offt     <= n_offt;
            r_target   <= n_target;
            r_done     <= n_done;
        end
    end

    a_time_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_time_inc == r_time + 32'd1)
        else $error("time increment shadow out of step");

    a_tick_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (i_cmd == CMD_TICK)) |=> (r_time == $past(r_time) + 32'd1))
        else $error("tick did not advance time by one");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_pulse && r_blink))
        else $error("pulse and blink active together");

endmodule

>>> rtl/relay_pulse_blink_driver_top.sv
// Relay pulse/blink driver: input stage, core, result stage and APB registers.
// Commands wait in the input stage; each core step registers its result onto o_m_tdata.
// Throughput: one command per cycle unless stalled, from the core's single-pass update.
// Reset (synchronous, active low): clock, timers and relay state to zero,
// relay enabled, polarity active high, guard interval zero; both stages empty.
// Depends on rpb_pkg, rpb_apb_regs and rpb_core.
module relay_pulse_blink_driver_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    // duration [31:0], off_duration [63:32], repeat_count [71:64]
    input  logic [71:0]                i_s_tdata,
    // command [2:0]
    input  logic [2:0]                 i_s_tuser,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    // pin_level [0], relay_on [1], pulsing [2], blinking [3], zero [7:4]
    output logic [7:0]                 o_m_tdata,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rpb_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import rpb_pkg::*;

    t_cfg        w_cfg;
    t_res        w_res;
    logic        w_adv;
    logic        w_step;
    logic        r_in_valid;
    logic [2:0]  r_in_cmd;
    logic [71:0] r_in_data;
    logic        r_out_valid;
    t_res        r_out;

    rpb_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_adv      = !r_out_valid || i_m_tready;
    assign w_step     = r_in_valid && w_adv;
    assign o_s_tready = !r_in_valid || w_adv;

    rpb_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_step  (w_step),
        .i_cmd   (r_in_cmd),
        .i_dur   (r_in_data[31:0]),
        .i_off   (r_in_data[63:32]),
        .i_rep   (r_in_data[71:64]),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready) r_in_valid  <= i_s_tvalid;
            if (w_adv)      r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_cmd  <= i_s_tuser;
            r_in_data <= i_s_tdata;
        end
        if (w_step) r_out <= w_res;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_out};

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_in_data) && $stable(r_in_cmd)))
        else $error("stalled command lost from input stage");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_step))
        else $error("result appeared without a core step");

endmodule

>>> bench/relay_pulse_blink_driver_checker.sv
// Checker for the relay pulse/blink driver: tracks command, status and APB transactions,
// predicts the relay status of every accepted command and compares it with the outputs.
// Depends on rpb_pkg.
module relay_pulse_blink_driver_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    input  logic                       i_s_tready,
    // duration [31:0], off_duration [63:32], repeat_count [71:64]
    input  logic [71:0]                i_s_tdata,
    // command [2:0]
    input  logic [2:0]                 i_s_tuser,
    input  logic                       i_m_tvalid,
    input  logic                       i_m_tready,
    // pin_level [0], relay_on [1], pulsing [2], blinking [3], zero [7:4]
    input  logic [7:0]                 i_m_tdata,
    input  logic                       i_psel,
    input  logic                       i_penable,
    input  logic                       i_pwrite,
    input  logic [rpb_pkg::ADDR_W-1:0] i_paddr,
    input  logic [31:0]                i_pwdata,
    input  logic [31:0]                i_prdata,
    input  logic                       i_pready,
    output int unsigned                o_fail_count,
    output int unsigned                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import rpb_pkg::*;

    // configuration copy
    logic        cfg_enabled;
    logic        cfg_act_low;
    logic        cfg_init_on;
    logic [31:0] cfg_guard_ms;

    // controller state copy
    logic [31:0] clk_ms;
    logic [31:0] last_sw_ms;
    logic        relay_q;
    logic        pulse_run;
    logic [31:0] pulse_t0;
    logic [31:0] pulse_len;
    logic        blink_run;
    logic [31:0] blink_t0;
    logic [31:0] blink_on_ms;
    logic [31:0] blink_off_ms;
    logic [7:0]  blink_goal;
    logic [7:0]  blink_cycles;

    t_res        status_due[$];
    int unsigned fail_total = 0;
    int unsigned due_count = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = due_count;

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_total++;
        end
    endtask

    // switch unless the guard interval since the last switch has not yet run out
    task automatic guarded_switch(input logic want);
        logic [31:0] since;
        since = clk_ms - last_sw_ms;
        if (cfg_guard_ms == 0 || since >= cfg_guard_ms) begin
            relay_q    = want;
            last_sw_ms = clk_ms;
        end
    endtask

    task automatic run_timers();
        logic [31:0] pulse_age;
        logic [31:0] phase_age;
        pulse_age = clk_ms - pulse_t0;
        if (pulse_run && pulse_age >= pulse_len) begin
            pulse_run = 1'b0;
            guarded_switch(1'b0);
        end
        phase_age = clk_ms - blink_t0;
        if (blink_run) begin
            // phase follows the real relay state, refused or not
            if (relay_q) begin
                if (phase_age >= blink_on_ms) begin
                    guarded_switch(1'b0);
                    blink_t0 = clk_ms;
                end
            end else if (phase_age >= blink_off_ms) begin
                blink_cycles = blink_cycles + 8'd1;
                if (blink_goal != 0 && blink_cycles >= blink_goal) begin
                    blink_run = 1'b0;
                end else begin
                    guarded_switch(1'b1);
                    blink_t0 = clk_ms;
                end
            end
        end
    endtask

    task automatic advance_relay(input logic [2:0] cmd, input logic [31:0] dur,
                                 input logic [31:0] offd, input logic [7:0] rep,
                                 output t_res status);
        if (cmd == CMD_TICK) begin
            clk_ms = clk_ms + 32'd1;
            if (cfg_enabled)
                run_timers();
        end else if (cfg_enabled) begin
            case (cmd)
                CMD_ON: begin
                    pulse_run = 1'b0;
                    blink_run = 1'b0;
                    guarded_switch(1'b1);
                end
                CMD_OFF: begin
                    pulse_run = 1'b0;
                    blink_run = 1'b0;
                    guarded_switch(1'b0);
                end
                CMD_TOGGLE: begin
                    pulse_run = 1'b0;
                    blink_run = 1'b0;
                    guarded_switch(~relay_q);
                end
                CMD_PULSE: begin
                    if (dur != 0) begin
                        blink_run = 1'b0;
                        guarded_switch(1'b1);
                        pulse_run = 1'b1;
                        pulse_t0  = clk_ms;
                        pulse_len = dur;
                    end
                end
                CMD_BLINK: begin
                    if (dur != 0 && offd != 0) begin
                        pulse_run    = 1'b0;
                        blink_on_ms  = dur;
                        blink_off_ms = offd;
                        blink_goal   = rep;
                        blink_cycles = 8'd0;
                        blink_run    = 1'b1;
                        blink_t0     = clk_ms;
                        guarded_switch(1'b1);
                    end
                end
                default: ;
            endcase
        end
        status.pin_level = cfg_enabled ? (relay_q ^ cfg_act_low) : 1'b0;
        status.relay_on  = relay_q;
        status.pulsing   = pulse_run;
        status.blinking  = blink_run;
    endtask

    always @(posedge i_clk) begin
        t_res        want;
        t_res        got;
        logic [31:0] reg_want;
        if (!i_rst_n) begin
            cfg_enabled  = 1'b1;
            cfg_act_low  = 1'b0;
            cfg_init_on  = 1'b0;
            cfg_guard_ms = '0;
            clk_ms       = '0;
            last_sw_ms   = '0;
            relay_q      = 1'b0;
            pulse_run    = 1'b0;
            pulse_t0     = '0;
            pulse_len    = '0;
            blink_run    = 1'b0;
            blink_t0     = '0;
            blink_on_ms  = '0;
            blink_off_ms = '0;
            blink_goal   = '0;
            blink_cycles = '0;
            status_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (status_due.size() == 0) begin
                    $error("status transaction %0h with no prediction waiting", i_m_tdata);
                    fail_total++;
                end else begin
                    want = status_due.pop_front();
                    got  = t_res'(i_m_tdata[3:0]);
                    check_field("pin_level", want.pin_level, got.pin_level);
                    check_field("relay_on", want.relay_on, got.relay_on);
                    check_field("pulsing", want.pulsing, got.pulsing);
                    check_field("blinking", want.blinking, got.blinking);
                    check_field("padding", 4'd0, i_m_tdata[7:4]);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                advance_relay(i_s_tuser, i_s_tdata[31:0], i_s_tdata[63:32], i_s_tdata[71:64],
                              want);
                status_due.push_back(want);
            end
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    case (t_reg_idx'(i_paddr[3:2]))
                        REG_RELAY_ENABLED: cfg_enabled = i_pwdata[0];
                        REG_ACTIVE_LOW:    cfg_act_low = i_pwdata[0];
                        REG_INITIAL_ON: begin
                            // re-initialises the relay only while it is enabled
                            cfg_init_on = i_pwdata[0];
                            if (cfg_enabled)
                                relay_q = i_pwdata[0];
                        end
                        REG_MIN_INTERVAL:  cfg_guard_ms = i_pwdata;
                        default: ;
                    endcase
                end else begin
                    case (t_reg_idx'(i_paddr[3:2]))
                        REG_RELAY_ENABLED: reg_want = {31'd0, cfg_enabled};
                        REG_ACTIVE_LOW:    reg_want = {31'd0, cfg_act_low};
                        REG_INITIAL_ON:    reg_want = {31'd0, cfg_init_on};
                        default:           reg_want = cfg_guard_ms;
                    endcase
                    check_field("prdata", reg_want, i_prdata);
                end
            end
        end
        due_count = status_due.size();
    end

endmodule

>>> bench/relay_pulse_blink_driver_top_test.sv
// Testbench top for the relay pulse/blink driver: clock, reset, command and APB stimulus,
// status-side back-pressure, watchdog and verdict.
// Depends on rpb_pkg, relay_pulse_blink_driver_top and relay_pulse_blink_driver_checker.
module relay_pulse_blink_driver_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rpb_pkg::*;

    localparam int unsigned WATCHDOG_CYCLES = 2000;
    localparam int unsigned DRAIN_CYCLES    = 4;
    localparam int unsigned ITEMS_PER_SET   = 120;
    localparam int unsigned ITEMS_PER_PHASE = 30;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [71:0]       s_tdata = '0;
    logic [2:0]        s_tuser = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [7:0]        m_tdata;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned send_gap_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned quiet_cycles = 0;

    always #5 clk = ~clk;

    relay_pulse_blink_driver_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    relay_pulse_blink_driver_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_CYCLES);
        $display("Simulation FAILED");
        $finish;
    end

    // entered and left at a falling edge
    task automatic send_cmd(input logic [2:0] cmd, input logic [31:0] dur,
                            input logic [31:0] offd, input logic [7:0] rep);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {rep, offd, dur};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // mostly short times so timers expire within the run
    function automatic logic [31:0] pick_ms();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 6)
            return '0;
        else if (roll < 12)
            return $urandom;
        else
            return 32'($urandom_range(6, 1));
    endfunction

    task automatic rand_item();
        int unsigned pick;
        logic [2:0]  cmd;
        logic [7:0]  rep;
        pick = $urandom_range(99);
        if (pick < 45)
            cmd = CMD_TICK;
        else if (pick < 53)
            cmd = CMD_ON;
        else if (pick < 60)
            cmd = CMD_OFF;
        else if (pick < 67)
            cmd = CMD_TOGGLE;
        else if (pick < 81)
            cmd = CMD_PULSE;
        else if (pick < 96)
            cmd = CMD_BLINK;
        else
            cmd = 3'($urandom_range(7, 6));
        rep = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(4));
        send_cmd(cmd, pick_ms(), pick_ms(), rep);
    endtask

    // stop sending, let every status transaction through, then give the pipeline time
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    // setup and access phase; psel is left high
    task automatic apb_access(input logic wr, input t_reg_idx idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // write then read back, which also covers the reload of the relay state
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        apb_access(1'b1, idx, val);
        apb_access(1'b0, idx, '0);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    initial begin
        logic        en;
        logic        act_low;
        logic        init_on;
        logic [31:0] guard;
        int unsigned gap_tab[4];
        int unsigned stall_tab[4];
        int unsigned ph;
        gap_tab   = '{0, 68, 0, 8};
        stall_tab = '{0, 0, 68, 8};

        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset configuration, no idling
        send_cmd(CMD_TICK, '1, '1, '1);
        send_cmd(CMD_ON, '0, '0, '0);
        send_cmd(CMD_OFF, '0, '0, '0);
        send_cmd(CMD_TOGGLE, '0, '0, '0);
        send_cmd(3'd6, 32'h0000_0005, 32'h0000_0001, 8'd1);
        send_cmd(3'd7, '1, '1, '1);
        send_cmd(CMD_BLINK, 32'd2, 32'd1, 8'd2);
        // zero-length pulse must leave the blink running
        send_cmd(CMD_PULSE, '0, 32'd3, 8'd0);
        repeat (6)
            send_cmd(CMD_TICK, '0, '0, '0);
        send_cmd(CMD_BLINK, '0, 32'd5, 8'd1);
        send_cmd(CMD_BLINK, 32'd5, '0, 8'd1);
        send_cmd(CMD_PULSE, 32'd3, '0, 8'd0);
        repeat (3)
            send_cmd(CMD_TICK, '0, '0, '0);
        send_cmd(CMD_PULSE, '1, '1, '1);
        send_cmd(CMD_BLINK, '1, '1, 8'hFF);
        // endless blink
        send_cmd(CMD_BLINK, 32'd1, 32'd1, 8'd0);
        repeat (2)
            send_cmd(CMD_TICK, '1, '1, '1);

        for (int unsigned s = 0; s < 6; s++) begin
            case (s)
                0: begin en = 1'b1; act_low = 1'b0; init_on = 1'b0; guard = '0; end
                1: begin en = 1'b1; act_low = 1'b1; init_on = 1'b0; guard = 32'd3; end
                2: begin en = 1'b0; act_low = 1'b0; init_on = 1'b1; guard = '0; end
                3: begin en = 1'b1; act_low = 1'b0; init_on = 1'b1; guard = '1; end
                4: begin en = 1'b1; act_low = 1'b1; init_on = 1'b0; guard = 32'd1; end
                default: begin en = 1'b1; act_low = 1'b0; init_on = 1'b1; guard = 32'd2; end
            endcase
            wait_quiet();
            write_reg(REG_RELAY_ENABLED, {31'd0, en});
            write_reg(REG_ACTIVE_LOW, {31'd0, act_low});
            write_reg(REG_INITIAL_ON, {31'd0, init_on});
            write_reg(REG_MIN_INTERVAL, guard);
            for (int unsigned n = 0; n < ITEMS_PER_SET; n++) begin
                if (n % ITEMS_PER_PHASE == 0) begin
                    ph             = (n / ITEMS_PER_PHASE + s) % 4;
                    send_gap_pct   = gap_tab[ph];
                    recv_stall_pct = stall_tab[ph];
                end
                rand_item();
            end
        end

        wait_quiet();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> filelist.f
rtl/rpb_pkg.sv
rtl/rpb_apb_regs.sv
rtl/rpb_core.sv
rtl/relay_pulse_blink_driver_top.sv
bench/relay_pulse_blink_driver_checker.sv
bench/relay_pulse_blink_driver_top_test.sv
